// File: hw/rtl/sliding_window_kth_smallest_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window rank-order filter
// Short forms for clocked implications, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_KTH_SMALLEST_ASSERT_SVH
`define SLIDING_WINDOW_KTH_SMALLEST_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWKTH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWKTH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/swkth_pkg.sv
// ----------------------------------------------------------------------------
// swkth_pkg
// Types and constants shared by the sliding window rank-order filter.
// ----------------------------------------------------------------------------
package swkth_pkg;

	localparam int SAMPLE_BITS    = 7;
	localparam int VALUE_OFFSET   = 50;
	localparam int NUM_BINS       = 2 * VALUE_OFFSET + 1;
	localparam int BIN_BITS       = $clog2(NUM_BINS);
	localparam int REG_BITS       = 7;
	localparam int REG_INDEX_BITS = 1;
	localparam int DEF_MAX_WINDOW = 64;
	localparam int QUEUE_DEPTH    = 2;

	// register indexes
	localparam logic [REG_INDEX_BITS-1:0] REG_WINDOW_LEN = 1'b0;
	localparam logic [REG_INDEX_BITS-1:0] REG_RANK_INDEX = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          restart;
	} sample_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] beauty;
		logic                          rank_error;
	} result_item_t;

	// classified item as it travels through the queue
	typedef struct packed {
		logic [BIN_BITS-1:0] bin;
		logic                restart;
	} queue_item_t;

	typedef struct packed {
		logic [REG_BITS-1:0] window_len;
		logic [REG_BITS-1:0] rank_index;
		logic                clear;
	} back_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_OLD_HRD,
		ST_OLD_HWR,
		ST_NEW_HRD,
		ST_NEW_HWR,
		ST_SCAN,
		ST_EMIT
	} back_state_t;

endpackage

// File: hw/rtl/swkth_ram.sv
// ----------------------------------------------------------------------------
// swkth_ram
// Generic memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swkth_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/swkth_front.sv
// ----------------------------------------------------------------------------
// swkth_front
// Input stage: take a sample transaction, clamp it and map it to a bin.
// ----------------------------------------------------------------------------
module swkth_front
	import swkth_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         sample_valid,
	output logic         sample_stall,
	input  sample_item_t sample_data,
	output logic         push_valid,
	input  logic         push_ready,
	output queue_item_t  push_item
);

	logic        valid_s1;
	queue_item_t item_s1;
	queue_item_t item_cls;
	logic        accept;

	// clamp to the histogram range, then offset to a bin number
	always_comb begin
		item_cls.restart = sample_data.restart;
		if (sample_data.sample < -VALUE_OFFSET) begin
			item_cls.bin = '0;
		end else if (sample_data.sample > VALUE_OFFSET) begin
			item_cls.bin = BIN_BITS'(NUM_BINS - 1);
		end else begin
			item_cls.bin = BIN_BITS'(int'(sample_data.sample) + VALUE_OFFSET);
		end
	end

	assign sample_stall = valid_s1 && !push_ready;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_cls;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

// File: hw/rtl/swkth_fifo.sv
// ----------------------------------------------------------------------------
// swkth_fifo
// Short queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module swkth_fifo
	import swkth_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push_valid,
	output logic        push_ready,
	input  queue_item_t push_item,
	output logic        pop_valid,
	input  logic        pop_ready,
	output queue_item_t pop_item
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	queue_item_t         entry_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (int'(count_q) < DEPTH);
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: hw/rtl/swkth_back.sv
// ----------------------------------------------------------------------------
// swkth_back
// Back end: window update, histogram count update, rank scan, result register.
// ----------------------------------------------------------------------------
module swkth_back
	import swkth_pkg::*;
#(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic         clk,
	input  logic         arst_n,
	input  back_cfg_t    cfg,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  queue_item_t  pop_item,
	output logic         result_valid,
	input  logic         result_stall,
	output result_item_t result_data
);

	localparam int EFF_MAX   = (MAX_WINDOW < (2 ** REG_BITS) - 1) ? MAX_WINDOW
	                                                               : (2 ** REG_BITS) - 1;
	localparam int LEN_BITS  = $clog2(EFF_MAX + 1);
	localparam int PTR_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CMP_BITS  = (PTR_BITS + 1 > LEN_BITS) ? PTR_BITS + 1 : LEN_BITS;
	localparam int ACC_BITS  = ((LEN_BITS > REG_BITS) ? LEN_BITS : REG_BITS) + 1;

	back_state_t         state_q, state_d;
	logic [PTR_BITS-1:0] wp_q;
	logic [LEN_BITS-1:0] fill_q;
	logic                full_q;
	logic [NUM_BINS-1:0] hvalid_q;
	logic [BIN_BITS-1:0] cur_bin_q;
	logic [BIN_BITS-1:0] old_bin_q;
	logic [BIN_BITS-1:0] scan_idx_q;
	logic [BIN_BITS-1:0] pbin_s1;
	logic                pend_s1;
	logic [ACC_BITS-1:0] acc_q;
	result_item_t        res_q;
	logic                out_valid_q;
	result_item_t        out_data_q;

	logic [LEN_BITS-1:0] len_eff;
	logic                rank_err;
	logic [PTR_BITS-1:0] wp_eff;
	logic [PTR_BITS-1:0] wp_next;
	logic [LEN_BITS-1:0] fill_new;
	logic                out_free;

	// window store
	logic                win_we, win_re;
	logic [BIN_BITS-1:0] win_rdata;

	// histogram store
	logic                hist_we, hist_re;
	logic [BIN_BITS-1:0] hist_waddr, hist_raddr;
	logic [LEN_BITS-1:0] hist_wdata, hist_rdata;
	logic [LEN_BITS-1:0] old_cnt, new_cnt, scan_cnt;
	logic [ACC_BITS-1:0] acc_n;
	logic                hit;

	always_comb begin
		if (cfg.window_len == '0) begin
			len_eff = LEN_BITS'(1);
		end else if (int'(cfg.window_len) > EFF_MAX) begin
			len_eff = LEN_BITS'(EFF_MAX);
		end else begin
			len_eff = LEN_BITS'(cfg.window_len);
		end
	end

	assign rank_err = (cfg.rank_index == '0) ||
	                  (ACC_BITS'(cfg.rank_index) > ACC_BITS'(len_eff));
	assign wp_eff   = (CMP_BITS'(wp_q) >= CMP_BITS'(len_eff)) ? '0 : wp_q;
	assign wp_next  = (CMP_BITS'(wp_q) + CMP_BITS'(1) >= CMP_BITS'(len_eff)) ? '0
	                                                                         : wp_q + PTR_BITS'(1);
	assign fill_new = full_q ? len_eff : fill_q + LEN_BITS'(1);
	assign out_free = !out_valid_q || !result_stall;

	// bins not written since the last clear read as zero
	assign old_cnt  = hvalid_q[old_bin_q] ? hist_rdata : '0;
	assign new_cnt  = hvalid_q[cur_bin_q] ? hist_rdata : '0;
	assign scan_cnt = hvalid_q[pbin_s1] ? hist_rdata : '0;
	assign acc_n    = acc_q + ACC_BITS'(scan_cnt);
	assign hit      = (acc_n >= ACC_BITS'(cfg.rank_index));

	assign pop_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d    = state_q;
		win_we     = 1'b0;
		win_re     = 1'b0;
		hist_we    = 1'b0;
		hist_re    = 1'b0;
		hist_waddr = cur_bin_q;
		hist_raddr = cur_bin_q;
		hist_wdata = '0;
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (fill_q >= len_eff) begin
					win_re  = 1'b1;
					state_d = ST_OLD_HRD;
				end else begin
					state_d = ST_NEW_HRD;
				end
			end
			ST_OLD_HRD: begin
				hist_re    = 1'b1;
				hist_raddr = win_rdata;
				state_d    = ST_OLD_HWR;
			end
			ST_OLD_HWR: begin
				hist_we    = 1'b1;
				hist_waddr = old_bin_q;
				hist_wdata = (old_cnt == '0) ? '0 : old_cnt - LEN_BITS'(1);
				state_d    = ST_NEW_HRD;
			end
			ST_NEW_HRD: begin
				hist_re = 1'b1;
				win_we  = 1'b1;
				state_d = ST_NEW_HWR;
			end
			ST_NEW_HWR: begin
				hist_we    = 1'b1;
				hist_wdata = new_cnt + LEN_BITS'(1);
				if (fill_new < len_eff) begin
					state_d = ST_IDLE;
				end else if (rank_err) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				hist_re    = (int'(scan_idx_q) < NUM_BINS);
				hist_raddr = scan_idx_q;
				if (pend_s1 && (hit || int'(pbin_s1) == NUM_BINS - 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// window bookkeeping and histogram valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			fill_q   <= '0;
			full_q   <= 1'b0;
			hvalid_q <= '0;
		end else if (cfg.clear || (state_q == ST_IDLE && pop_valid && pop_item.restart)) begin
			wp_q     <= '0;
			fill_q   <= '0;
			hvalid_q <= '0;
		end else begin
			case (state_q)
				ST_START: begin
					wp_q   <= wp_eff;
					full_q <= (fill_q >= len_eff);
				end
				ST_OLD_HWR: begin
					hvalid_q[old_bin_q] <= 1'b1;
				end
				ST_NEW_HWR: begin
					hvalid_q[cur_bin_q] <= 1'b1;
					wp_q                <= wp_next;
					fill_q              <= fill_new;
				end
				default: begin
				end
			endcase
		end
	end

	// scan pipeline and item payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			pend_s1 <= (int'(scan_idx_q) < NUM_BINS);
		end else begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cur_bin_q <= pop_item.bin;
			end
			ST_OLD_HRD: begin
				old_bin_q <= win_rdata;
			end
			ST_NEW_HWR: begin
				scan_idx_q       <= '0;
				acc_q            <= '0;
				res_q.beauty     <= '0;
				res_q.rank_error <= 1'b1;
			end
			ST_SCAN: begin
				scan_idx_q <= scan_idx_q + BIN_BITS'(1);
				pbin_s1    <= scan_idx_q;
				if (pend_s1) begin
					acc_q <= acc_n;
				end
				res_q.rank_error <= 1'b0;
				if (int'(pbin_s1) < VALUE_OFFSET) begin
					res_q.beauty <= SAMPLE_BITS'(int'(pbin_s1) - VALUE_OFFSET);
				end else begin
					res_q.beauty <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_data_q <= res_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_data_q;

	swkth_ram #(
		.WIDTH (BIN_BITS),
		.DEPTH (MAX_WINDOW)
	) u_win_ram (
		.clk   (clk),
		.we    (win_we),
		.waddr (wp_q),
		.wdata (cur_bin_q),
		.re    (win_re),
		.raddr (wp_eff),
		.rdata (win_rdata)
	);

	swkth_ram #(
		.WIDTH (LEN_BITS),
		.DEPTH (NUM_BINS)
	) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (hist_re),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

endmodule

// File: hw/rtl/sliding_window_kth_smallest.sv
// ----------------------------------------------------------------------------
// sliding_window_kth_smallest
// Sliding-window rank-order filter with histogram selection.
// ----------------------------------------------------------------------------
// Each sample transaction enters a window of the last window_len samples
// (clamped to -50..50); once the window is full, every sample gives one
// result transaction carrying the rank_index-th smallest value in the window,
// or 0 if that value is not negative, and rank_error with a zero value when
// rank_index is 0 or above the window length. While the window fills, no
// result appears. The back end takes each sample through a start state, a
// histogram read and write for the evicted sample once the window is full,
// and a read and write for the new one; a ranked result then scans the
// histogram one bin per cycle through the memory's single read port. No new
// sample is taken until idle again; result stalls hold the emit state. The
// front end keeps taking samples into a two-entry queue meanwhile. The
// histogram is cleared at once through one valid flag per bin, so no
// clearing pass follows reset, restart or a window_len write. Configuration
// is meant to be written while idle; a window_len write clears the window.
// ----------------------------------------------------------------------------
module sliding_window_kth_smallest
	import swkth_pkg::*;
#(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// sample channel
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  sample_item_t              sample_data,
	// result channel
	output logic                      result_valid,
	input  logic                      result_stall,
	output result_item_t              result_data,
	// configuration write port
	input  logic                      wr_en,
	input  logic [REG_INDEX_BITS-1:0] wr_index,
	input  logic [REG_BITS-1:0]       wr_data
);

	logic [REG_BITS-1:0] window_len_q;
	logic [REG_BITS-1:0] rank_index_q;
	back_cfg_t           back_cfg;

	logic        push_valid, push_ready;
	queue_item_t push_item;
	logic        pop_valid, pop_ready;
	queue_item_t pop_item;

	// configuration registers; hold until rewritten
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= REG_BITS'(1);
			rank_index_q <= REG_BITS'(1);
		end else if (wr_en) begin
			case (wr_index)
				REG_WINDOW_LEN: window_len_q <= wr_data;
				REG_RANK_INDEX: rank_index_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// a window_len write drops the whole window in the same cycle
	assign back_cfg.window_len = window_len_q;
	assign back_cfg.rank_index = rank_index_q;
	assign back_cfg.clear      = wr_en && (wr_index == REG_WINDOW_LEN);

	// front end: accept and classify each sample transaction
	swkth_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_data  (sample_data),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_item    (push_item)
	);

	// decouple front and back so each may stall on its own
	swkth_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// back end: update window and histogram, scan for the ranked value
	swkth_back #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (back_cfg),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

// File: hw/rtl/swkth_checker.sv
// ----------------------------------------------------------------------------
// swkth_checker
// Port-level checks on the result channel of the rank-order filter.
// ----------------------------------------------------------------------------
`include "sliding_window_kth_smallest_assert.svh"

module swkth_checker
	import swkth_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         result_valid,
	input logic         result_stall,
	input result_item_t result_data
);

	`SWKTH_ASSERT_NEXT(a_valid_held, clk, arst_n, result_valid && result_stall, result_valid, "result valid dropped while stalled")
	`SWKTH_ASSERT_NEXT(a_data_held, clk, arst_n, result_valid && result_stall, $stable(result_data), "result payload changed while stalled")
	`SWKTH_ASSERT_NOW(a_err_zero, clk, arst_n, result_valid && result_data.rank_error, result_data.beauty == '0, "rank error with nonzero value")
	`SWKTH_ASSERT_NOW(a_not_pos, clk, arst_n, result_valid, result_data.beauty[SAMPLE_BITS-1] || (result_data.beauty == '0), "positive result value")

endmodule

bind sliding_window_kth_smallest swkth_checker u_swkth_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_data  (result_data)
);

// File: dv/sliding_window_kth_smallest_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_kth_smallest_tb
// Self-checking bench for the sliding-window rank-order filter.
// ----------------------------------------------------------------------------
// A stimulus process fills a queue of sample transactions phase by phase,
// reprograms rank_index and mostly window_len between phases once the block
// has drained. A clocked driver offers the queued samples with random gaps.
// On every accepted sample it updates a histogram-based copy of the filter
// and queues the ranked value that the block must return. A clocked monitor
// stalls at random, once for a long hold-off, and checks each result
// transaction against the oldest queued value.
// ----------------------------------------------------------------------------
module sliding_window_kth_smallest_tb;
	import swkth_pkg::*;

	localparam int WIN_DEPTH    = DEF_MAX_WINDOW;
	localparam int DRAIN_CYCLES = 400;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int ITEM_TARGET  = 1850;
	localparam int HOLD_CYCLES  = 1500;
	localparam int QUIET_START  = 30000;
	localparam int QUIET_END    = 60000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                      sample_valid = 1'b0;
	logic                      sample_stall;
	sample_item_t              sample_data = '0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	result_item_t              result_data;
	logic                      wr_en = 1'b0;
	logic [REG_INDEX_BITS-1:0] wr_index = '0;
	logic [REG_BITS-1:0]       wr_data = '0;

	sliding_window_kth_smallest dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_data  (sample_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	// Samples waiting to be offered, and ranked values still owed by the block
	sample_item_t pending_samples[$];
	result_item_t owed_ranks[$];

	int unsigned cycle = 0;
	int unsigned fail_count = 0;
	int unsigned results_seen = 0;
	int unsigned samples_queued = 0;

	// Shadow copy of the filter: registers, circular store and histogram
	logic [REG_BITS-1:0] shadow_wlen = 7'd1;
	logic [REG_BITS-1:0] shadow_rank = 7'd1;
	logic [BIN_BITS-1:0] shadow_bins [WIN_DEPTH];
	int unsigned         shadow_hist [NUM_BINS];
	int unsigned         shadow_wp = 0;
	int unsigned         shadow_fill = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bound the run; a hung handshake ends here
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int unsigned live_len(logic [REG_BITS-1:0] wl);
		if (wl == 0)
			return 1;
		if (wl > WIN_DEPTH)
			return WIN_DEPTH;
		return wl;
	endfunction

	function automatic void empty_window();
		foreach (shadow_hist[i])
			shadow_hist[i] = 0;
		shadow_wp = 0;
		shadow_fill = 0;
	endfunction

	// Mirror a register write; any window_len write empties the window
	function automatic void mirror_reg(logic [REG_INDEX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
		if (idx == REG_WINDOW_LEN) begin
			shadow_wlen = val;
			empty_window();
		end else if (idx == REG_RANK_INDEX) begin
			shadow_rank = val;
		end
	endfunction

	// Push one accepted sample through the shadow window and queue its rank, if any
	function automatic void rank_sample(sample_item_t it);
		int          s;
		int          sel;
		int unsigned bin;
		int unsigned len;
		int unsigned acc;
		int unsigned old;
		result_item_t r;

		if (it.restart)
			empty_window();

		// clamp to the histogram range
		s = $signed(it.sample);
		if (s < -VALUE_OFFSET)
			s = -VALUE_OFFSET;
		if (s > VALUE_OFFSET)
			s = VALUE_OFFSET;
		bin = s + VALUE_OFFSET;

		len = live_len(shadow_wlen);
		if (shadow_wp >= len)
			shadow_wp = 0;

		// evict the oldest sample once the window is full
		if (shadow_fill >= len) begin
			old = shadow_bins[shadow_wp];
			if (shadow_hist[old] > 0)
				shadow_hist[old]--;
			shadow_fill = len;
		end else begin
			shadow_fill++;
		end
		shadow_bins[shadow_wp] = bin;
		shadow_hist[bin]++;
		shadow_wp = (shadow_wp + 1 >= len) ? 0 : shadow_wp + 1;

		if (shadow_fill < len)
			return;

		if (shadow_rank == 0 || shadow_rank > len) begin
			r.beauty = '0;
			r.rank_error = 1'b1;
			owed_ranks = {owed_ranks, r};
			return;
		end

		// walk the histogram up to the requested rank
		sel = VALUE_OFFSET;
		acc = 0;
		for (int b = 0; b < NUM_BINS; b++) begin
			acc += shadow_hist[b];
			if (acc >= shadow_rank) begin
				sel = b - VALUE_OFFSET;
				break;
			end
		end
		if (sel > 0)
			sel = 0;
		r.beauty = sel[SAMPLE_BITS-1:0];
		r.rank_error = 1'b0;
		owed_ranks = {owed_ranks, r};
	endfunction

	// Driver: hold a stalled transaction, otherwise advance to the next queued sample
	always @(posedge clk) begin
		if (!sample_valid || !sample_stall) begin
			if (sample_valid)
				rank_sample(sample_data);
			if (pending_samples.size() != 0 &&
			    ((cycle >= QUIET_START && cycle < QUIET_END) || $urandom_range(99) >= 7)) begin
				sample_valid <= 1'b1;
				sample_data <= pending_samples.pop_front();
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each result transaction and drive the stall
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	always @(posedge clk) begin
		result_item_t want;

		if (result_valid && !result_stall) begin
			results_seen <= results_seen + 1;
			if (owed_ranks.size() == 0) begin
				$error("unexpected result: beauty %0d rank_error %0b",
				       $signed(result_data.beauty), result_data.rank_error);
				fail_count++;
			end else begin
				want = owed_ranks.pop_front();
				if (result_data.beauty !== want.beauty) begin
					$error("beauty: expected %0d, actual %0d",
					       $signed(want.beauty), $signed(result_data.beauty));
					fail_count++;
				end
				if (result_data.rank_error !== want.rank_error) begin
					$error("rank_error: expected %0b, actual %0b",
					       want.rank_error, result_data.rank_error);
					fail_count++;
				end
			end
		end

		// One long hold-off while plenty of samples are still being offered,
		// so the input queue fills and the block stalls its sample channel
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else if (!hold_done && results_seen >= 100 && pending_samples.size() > 20) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !(cycle >= QUIET_START && cycle < QUIET_END) &&
			                ($urandom_range(99) < 7);
		end
	end

	task automatic queue_sample(int v, bit rs);
		sample_item_t it;

		it.sample = v[SAMPLE_BITS-1:0];
		it.restart = rs;
		pending_samples = {pending_samples, it};
		samples_queued++;
	endtask

	// Wait for the block to go idle: nothing offered, nothing owed, then let
	// any sample that produces no result work its way out of the back end
	task automatic drain();
		while (pending_samples.size() != 0 || sample_valid || owed_ranks.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [REG_INDEX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		mirror_reg(idx, val);
		@(posedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		int          phase;
		int unsigned wl;
		int unsigned rk;
		int unsigned eff;
		int unsigned n;
		int          v;

		empty_window();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values: window of one, rank one. Extremes and clamping.
		queue_sample(-64, 1'b0);
		queue_sample(63, 1'b0);
		queue_sample(-50, 1'b0);
		queue_sample(50, 1'b0);
		queue_sample(-51, 1'b0);
		queue_sample(51, 1'b0);
		queue_sample(0, 1'b0);
		queue_sample(-1, 1'b1);

		// Median of three, with a restart part-way through a full window
		drain();
		write_reg(REG_WINDOW_LEN, 7'd3);
		write_reg(REG_RANK_INDEX, 7'd2);
		queue_sample(-5, 1'b0);
		queue_sample(7, 1'b0);
		queue_sample(-20, 1'b0);
		queue_sample(-3, 1'b0);
		queue_sample(1, 1'b1);
		queue_sample(-9, 1'b0);
		queue_sample(-9, 1'b0);
		queue_sample(2, 1'b0);

		// Zero window length acts as one; zero rank is an error
		drain();
		write_reg(REG_WINDOW_LEN, 7'd0);
		write_reg(REG_RANK_INDEX, 7'd0);
		queue_sample(-7, 1'b0);
		queue_sample(12, 1'b0);
		queue_sample(-33, 1'b0);

		// Rank above the window length is an error
		drain();
		write_reg(REG_WINDOW_LEN, 7'd2);
		write_reg(REG_RANK_INDEX, 7'd5);
		queue_sample(-4, 1'b0);
		queue_sample(-8, 1'b0);
		queue_sample(3, 1'b0);

		// Random phases; the first three pin the register extremes
		phase = 0;
		while (samples_queued < ITEM_TARGET) begin
			drain();
			case (phase)
				0: begin wl = 127; rk = 127; end
				1: begin wl = 64; rk = 64; end
				2: begin wl = 64; rk = 1; end
				default: begin
					case ($urandom_range(9))
						0: wl = 0;
						1: wl = 64;
						2: wl = $urandom_range(127, 65);
						default: wl = $urandom_range(16, 1);
					endcase
					eff = live_len(wl[REG_BITS-1:0]);
					case ($urandom_range(9))
						0: rk = 0;
						1: rk = $urandom_range(127, eff + 1);
						2: rk = eff;
						default: rk = $urandom_range(eff, 1);
					endcase
				end
			endcase
			eff = live_len(wl[REG_BITS-1:0]);

			// Keep the previous window now and then: a rank write alone does not clear it
			if (phase < 3 || $urandom_range(4) != 0)
				write_reg(REG_WINDOW_LEN, wl[REG_BITS-1:0]);
			else
				eff = live_len(shadow_wlen);
			write_reg(REG_RANK_INDEX, rk[REG_BITS-1:0]);

			n = eff + $urandom_range(60, 20);
			repeat (n) begin
				if ($urandom_range(9) == 0)
					v = $signed($urandom_range(127, 0) & 7'h7F) - (($urandom_range(127, 0) & 64) ? 0 : 0);
				else
					v = $urandom_range(100, 0) - VALUE_OFFSET;
				if ($urandom_range(9) == 0)
					v = (v & 127) >= 64 ? (v & 127) - 128 : (v & 127);
				queue_sample(v, $urandom_range(99) < 3);
			end
			phase++;
		end

		drain();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
